/* rtl/rau_pkg.sv */
package rau_pkg;

  localparam int MagBitsDef = 16;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_DONE,
    KIND_SUM,
    KIND_MUL,
    KIND_DIV,
    KIND_CMP
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_ZDEN = 2'd1,
    ERR_DIVZ = 2'd2,
    ERR_OVF  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2
  } rel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } bst_e;

  typedef struct packed {
    kind_e kind;
    err_e  err;
    logic  a_neg;
    logic  b_neg;
  } ctrl_t;

endpackage

/* rtl/rau_front.sv */
module rau_front
  import rau_pkg::*;
#(
  parameter int MagBits = MagBitsDef
) (
  input  logic [2:0]         action_i,
  input  logic               a_negative_i,
  input  logic [MagBits-1:0] a_num_i,
  input  logic [MagBits-1:0] a_den_i,
  input  logic               b_negative_i,
  input  logic [MagBits-1:0] b_num_i,
  input  logic [MagBits-1:0] b_den_i,
  output ctrl_t              ctrl_o
);

  logic an, bn;

  always_comb begin
    an = a_negative_i & (|a_num_i);
    bn = b_negative_i & (|b_num_i);
    ctrl_o.kind  = KIND_DONE;
    ctrl_o.err   = ERR_OK;
    ctrl_o.a_neg = an;
    ctrl_o.b_neg = bn;
    case (action_i)
      OP_ADD: ctrl_o.kind = KIND_SUM;
      OP_SUB: begin
        ctrl_o.kind  = KIND_SUM;
        ctrl_o.b_neg = bn ^ (|b_num_i);
      end
      OP_MUL: ctrl_o.kind = KIND_MUL;
      OP_DIV: begin
        if (b_num_i == '0) begin
          ctrl_o.kind = KIND_DONE;
          ctrl_o.err  = ERR_DIVZ;
        end else begin
          ctrl_o.kind = KIND_DIV;
        end
      end
      OP_CMP: ctrl_o.kind = KIND_CMP;
      default: ctrl_o.kind = KIND_DONE;
    endcase
    if (action_i <= OP_CMP && (a_den_i == '0 || b_den_i == '0)) begin
      ctrl_o.kind = KIND_DONE;
      ctrl_o.err  = ERR_ZDEN;
    end
  end

endmodule

/* rtl/rau_queue.sv */
module rau_queue
  import rau_pkg::*;
#(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/rau_back.sv */
module rau_back
  import rau_pkg::*;
#(
  parameter int MagBits = MagBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ctrl_t              ctrl_i,
  input  logic [MagBits-1:0] a_i,
  input  logic [MagBits-1:0] b_i,
  input  logic [MagBits-1:0] c_i,
  input  logic [MagBits-1:0] d_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               res_negative_o,
  output logic [MagBits-1:0] res_num_o,
  output logic [MagBits-1:0] res_den_o,
  output rel_e               relation_o,
  output err_e               error_o
);

  localparam int PW = 2 * MagBits;
  localparam int W  = PW + 1;
  localparam int KW = $clog2(W + 1);

  bst_e               st_q, st_d;
  ctrl_t              ctrl_q, ctrl_d;
  logic [MagBits-1:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [PW-1:0]      p_q, p_d, q_q, q_d;
  logic [W-1:0]       u_q, u_d, v_q, v_d, rn_q, rn_d, rd_q, rd_d, g_q, g_d;
  logic [W-1:0]       qa_q, qa_d, qb_q, qb_d, ra_q, ra_d, rb_q, rb_d;
  logic [KW-1:0]      k_q, k_d, cnt_q, cnt_d;
  logic               neg_q, neg_d;
  rel_e               rel_q, rel_d;
  err_e               err_q, err_d;
  logic               ov_q, ov_d;
  logic               on_q, on_d;
  logic [MagBits-1:0] onum_q, onum_d, oden_q, oden_d;
  rel_e               orel_q, orel_d;
  err_e               oerr_q, oerr_d;
  logic [MagBits-1:0] mx, my;
  logic [PW-1:0]      prod;
  logic [W-1:0]       sum;
  logic [W-1:0]       nra, nqa, nrb, nqb;
  logic               fin_ovf;

  function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                              input logic [W-1:0] quo,
                                              input logic [W-1:0] g);
    logic [W:0] t;
    logic       ge;
    t  = {rem, quo[W-1]};
    ge = (t >= {1'b0, g});
    if (ge) begin
      t = t - {1'b0, g};
    end
    return {t[W-1:0], quo[W-2:0], ge};
  endfunction

  assign prod = PW'(mx) * PW'(my);
  assign {nra, nqa} = div_step(ra_q, qa_q, g_q);
  assign {nrb, nqb} = div_step(rb_q, qb_q, g_q);
  assign fin_ovf = (|qa_q[W-1:MagBits]) || (|qb_q[W-1:MagBits]);

  assign out_valid_o    = ov_q;
  assign res_negative_o = on_q;
  assign res_num_o      = onum_q;
  assign res_den_o      = oden_q;
  assign relation_o     = orel_q;
  assign error_o        = oerr_q;

  always_comb begin
    st_d   = st_q;
    ctrl_d = ctrl_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    p_d = p_q; q_d = q_q;
    u_d = u_q; v_d = v_q; rn_d = rn_q; rd_d = rd_q; g_d = g_q;
    qa_d = qa_q; qb_d = qb_q; ra_d = ra_q; rb_d = rb_q;
    k_d = k_q; cnt_d = cnt_q;
    neg_d = neg_q; rel_d = rel_q; err_d = err_q;
    ov_d = ov_q; on_d = on_q; onum_d = onum_q; oden_d = oden_q;
    orel_d = orel_q; oerr_d = oerr_q;
    pop_o = 1'b0;
    mx = a_q;
    my = d_q;
    sum = '0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (st_q)
      ST_IDLE: begin
        if (valid_i) begin
          pop_o  = 1'b1;
          ctrl_d = ctrl_i;
          a_d = a_i; b_d = b_i; c_d = c_i; d_d = d_i;
          rel_d = REL_LESS;
          err_d = ctrl_i.err;
          qa_d  = '0;
          qb_d  = '0;
          st_d  = (ctrl_i.kind == KIND_DONE) ? ST_FIN : ST_MUL0;
        end
      end
      ST_MUL0: begin
        mx = a_q;
        my = (ctrl_q.kind == KIND_MUL) ? c_q : d_q;
        p_d = prod;
        st_d = ST_MUL1;
      end
      ST_MUL1: begin
        mx = c_q;
        my = b_q;
        q_d = prod;
        st_d = ST_MUL2;
      end
      ST_MUL2: begin
        mx = b_q;
        my = (ctrl_q.kind == KIND_DIV) ? c_q : d_q;
        rd_d = {1'b0, prod};
        v_d  = {1'b0, prod};
        st_d = ST_COMB;
      end
      ST_COMB: begin
        if (ctrl_q.kind == KIND_CMP) begin
          if (ctrl_q.a_neg != ctrl_q.b_neg) begin
            rel_d = ctrl_q.a_neg ? REL_LESS : REL_GREATER;
          end else if (p_q == q_q) begin
            rel_d = REL_EQUAL;
          end else if ((p_q < q_q) != ctrl_q.a_neg) begin
            rel_d = REL_LESS;
          end else begin
            rel_d = REL_GREATER;
          end
          st_d = ST_FIN;
        end else begin
          if (ctrl_q.kind == KIND_SUM) begin
            if (ctrl_q.a_neg == ctrl_q.b_neg) begin
              sum   = {1'b0, p_q} + {1'b0, q_q};
              neg_d = ctrl_q.a_neg;
            end else if (p_q >= q_q) begin
              sum   = {1'b0, p_q - q_q};
              neg_d = ctrl_q.a_neg;
            end else begin
              sum   = {1'b0, q_q - p_q};
              neg_d = ctrl_q.b_neg;
            end
          end else begin
            sum   = {1'b0, p_q};
            neg_d = ctrl_q.a_neg ^ ctrl_q.b_neg;
          end
          if (sum == '0) begin
            neg_d = 1'b0;
          end
          rn_d = sum;
          u_d  = sum;
          k_d  = '0;
          st_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (u_q == '0) begin
          g_d   = v_q << k_q;
          qa_d  = rn_q;
          qb_d  = rd_q;
          ra_d  = '0;
          rb_d  = '0;
          cnt_d = KW'(W);
          st_d  = ST_DIV;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q >= v_q) begin
          u_d = u_q - v_q;
        end else begin
          v_d = v_q - u_q;
        end
      end
      ST_DIV: begin
        ra_d  = nra;
        qa_d  = nqa;
        rb_d  = nrb;
        qb_d  = nqb;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == KW'(1)) begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ov_q || out_ready_i) begin
          ov_d   = 1'b1;
          on_d   = 1'b0;
          onum_d = '0;
          oden_d = '0;
          orel_d = REL_LESS;
          oerr_d = err_q;
          if (err_q == ERR_OK) begin
            if (ctrl_q.kind == KIND_CMP) begin
              orel_d = rel_q;
            end else if (ctrl_q.kind != KIND_DONE) begin
              if (fin_ovf) begin
                oerr_d = ERR_OVF;
              end else begin
                on_d   = neg_q;
                onum_d = qa_q[MagBits-1:0];
                oden_d = qb_q[MagBits-1:0];
              end
            end
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q <= ctrl_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
    p_q <= p_d; q_q <= q_d;
    u_q <= u_d; v_q <= v_d; rn_q <= rn_d; rd_q <= rd_d; g_q <= g_d;
    qa_q <= qa_d; qb_q <= qb_d; ra_q <= ra_d; rb_q <= rb_d;
    k_q <= k_d; cnt_q <= cnt_d;
    neg_q <= neg_d; rel_q <= rel_d; err_q <= err_d;
    on_q <= on_d; onum_q <= onum_d; oden_q <= oden_d;
    orel_q <= orel_d; oerr_q <= oerr_d;
  end

endmodule

/* rtl/rational_arithmetic_unit_top.sv */
// Sequence: an item that ends in an error goes straight to the output stage; a compare
// runs the multiply states and the combine state; other kinds then add the binary GCD and the division by the GCD.
// Throughput: one item at a time in the back end, which is limited by the iterative GCD and the
// bit-serial division by the GCD; a two-entry queue takes new requests until it is full.
// Reset: asynchronous, active low; it empties the queue and the output register.
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int MagBits = MagBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // action, a_negative, a_num, a_den, b_negative, b_num, b_den, zero pad
  input  logic [((5+4*MagBits+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_negative, res_num, res_den, relation, error, zero pad
  output logic [((5+2*MagBits+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OutW = ((5 + 2 * MagBits + 7) / 8) * 8;
  localparam int EntW = $bits(ctrl_t) + 4 * MagBits;

  logic [2:0]         action;
  logic               a_neg, b_neg;
  logic [MagBits-1:0] a_num, a_den, b_num, b_den;
  ctrl_t              f_ctrl, q_ctrl;
  logic [MagBits-1:0] qa, qb, qc, qd;
  logic               q_full, q_valid, q_pop, push;
  logic [EntW-1:0]    q_out;
  logic               r_neg;
  logic [MagBits-1:0] r_num, r_den;
  rel_e               r_rel;
  err_e               r_err;

  assign action = s_axis_tdata[2:0];
  assign a_neg  = s_axis_tdata[3];
  assign a_num  = s_axis_tdata[4 +: MagBits];
  assign a_den  = s_axis_tdata[4 + MagBits +: MagBits];
  assign b_neg  = s_axis_tdata[4 + 2 * MagBits];
  assign b_num  = s_axis_tdata[5 + 2 * MagBits +: MagBits];
  assign b_den  = s_axis_tdata[5 + 3 * MagBits +: MagBits];

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  rau_front #(.MagBits(MagBits)) u_front (
    .action_i    (action),
    .a_negative_i(a_neg),
    .a_num_i     (a_num),
    .a_den_i     (a_den),
    .b_negative_i(b_neg),
    .b_num_i     (b_num),
    .b_den_i     (b_den),
    .ctrl_o      (f_ctrl)
  );

  rau_queue #(.Width(EntW)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({f_ctrl, a_num, a_den, b_num, b_den}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_out)
  );

  assign {q_ctrl, qa, qb, qc, qd} = q_out;

  rau_back #(.MagBits(MagBits)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .ctrl_i        (q_ctrl),
    .a_i           (qa),
    .b_i           (qb),
    .c_i           (qc),
    .d_i           (qd),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .res_negative_o(r_neg),
    .res_num_o     (r_num),
    .res_den_o     (r_den),
    .relation_o    (r_rel),
    .error_o       (r_err)
  );

  assign m_axis_tdata = OutW'({r_err, r_rel, r_den, r_num, r_neg});

endmodule
